// ===== rtl/core/assert_macros.svh =====
// Assertion macros included by binary_lifting_lca.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property, sampled on clk and held off while arst_n is low
`define BLL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Assert that a condition never holds outside reset
`define BLL_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/bll_pkg.sv =====
// Widths, function codes and the reset value for the binary lifting LCA block
package bll_pkg;
	localparam int NODE_W = 10;
	localparam int DEPTH_W = 10;
	localparam int JUMP_W = 10;
	localparam int FUNC_W = 2;

	localparam logic [FUNC_W-1:0] FN_LOAD = 2'd0;
	localparam logic [FUNC_W-1:0] FN_BUILD = 2'd1;
	localparam logic [FUNC_W-1:0] FN_KTH = 2'd2;
	localparam logic [FUNC_W-1:0] FN_LCA = 2'd3;

	localparam logic [NODE_W-1:0] NODE_COUNT_RST = 10'd1023;

	typedef logic [NODE_W-1:0] node_t;
	typedef logic [DEPTH_W-1:0] depth_t;
	typedef logic [JUMP_W-1:0] jump_t;
	typedef logic [FUNC_W-1:0] func_t;
endpackage

// ===== rtl/core/bll_if.sv =====
// Request and response channel interfaces of the binary lifting LCA block
interface bll_req_if;
	logic valid;
	logic ready;
	bll_pkg::func_t func;
	bll_pkg::node_t node_a;
	bll_pkg::node_t node_b;
	logic parent_none;
	bll_pkg::depth_t node_depth;
	bll_pkg::jump_t jump_count;

	modport source (output valid, func, node_a, node_b, parent_none, node_depth, jump_count,
		input ready);
	modport sink (input valid, func, node_a, node_b, parent_none, node_depth, jump_count,
		output ready);
endinterface

interface bll_rsp_if;
	logic valid;
	logic ready;
	bll_pkg::node_t result_node;
	logic found;

	modport source (output valid, result_node, found, input ready);
	modport sink (input valid, result_node, found, output ready);
endinterface

// ===== rtl/core/binary_lifting_lca.sv =====
// Binary lifting tree store with k-th ancestor and lowest common ancestor queries
//
// Requests arrive on req (valid/ready) and each gives exactly one response on rsp.
// func selects: load a node's parent and depth, build the jump table, k-th ancestor
// or lowest common ancestor. The user must write node_count through cfg_we/cfg_wdata only
// while idle; the block does not enforce this. One request is worked on at a time by a
// small sequencer around a single jump table memory with two registered read ports;
// req.ready is high only when the sequencer idles. Per function: load writes the parent
// and depth of node_a, build fills the jump table one entry per step, k-th ancestor does
// one table read per set bit of k, and LCA does a depth read, an equalising climb and a
// joint lift. The block takes a new request only after the previous one has finished and
// its result has moved to the output register.
// The jump table read latency sets the per-level cost of every query.
// After arst_n is released the parent store is cleared; no request is taken while it is.
// A finished response waits in an output register; the block returns to idle and may take
// the next request while rsp is stalled, but holds any later result until the held one
// is taken.
`include "assert_macros.svh"

module binary_lifting_lca #(
	parameter int NODES = 1024,
	parameter int LEVELS = 10
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input bll_pkg::node_t cfg_wdata,
	bll_req_if.sink req,
	bll_rsp_if.source rsp
);
	localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int LW = $clog2(LEVELS);
	localparam int JW = AW + LW;
	localparam int CW = (AW > bll_pkg::NODE_W) ? AW : bll_pkg::NODE_W;
	localparam int JDEPTH = NODES << LW;

	localparam logic [4:0] ST_CLR = 5'd0;
	localparam logic [4:0] ST_IDLE = 5'd1;
	localparam logic [4:0] ST_B0_RD = 5'd2;
	localparam logic [4:0] ST_B0_WR = 5'd3;
	localparam logic [4:0] ST_BH_RD1 = 5'd4;
	localparam logic [4:0] ST_BH_RD2 = 5'd5;
	localparam logic [4:0] ST_BH_WR = 5'd6;
	localparam logic [4:0] ST_K_STEP = 5'd7;
	localparam logic [4:0] ST_K_WAIT = 5'd8;
	localparam logic [4:0] ST_K_END = 5'd9;
	localparam logic [4:0] ST_L_DEP = 5'd10;
	localparam logic [4:0] ST_L_DIFF = 5'd11;
	localparam logic [4:0] ST_L_CHK = 5'd12;
	localparam logic [4:0] ST_L_LRD = 5'd13;
	localparam logic [4:0] ST_L_LCMP = 5'd14;
	localparam logic [4:0] ST_L_FRD = 5'd15;
	localparam logic [4:0] ST_L_FWAIT = 5'd16;
	localparam logic [4:0] ST_DONE = 5'd17;

	localparam logic [AW-1:0] CNT_LAST = AW'(NODES - 1);
	localparam logic [LW-1:0] LVL_LAST = LW'(LEVELS - 1);

	logic [4:0] state_q;
	bll_pkg::node_t node_count_q;
	logic [AW-1:0] cnt_q;
	logic [LW-1:0] lvl_q;
	logic [LW-1:0] lvl_m1;
	bll_pkg::node_t u_q, w_q, c_q, res_q;
	bll_pkg::jump_t k_q;
	logic lca_q, sel_q, midz_q;
	logic rsp_valid_q, rsp_found_q;
	bll_pkg::node_t rsp_node_q;

	bll_pkg::node_t par_mem [0:NODES-1];
	bll_pkg::depth_t dep_mem [0:NODES-1];
	bll_pkg::node_t jt_mem [0:JDEPTH-1];

	bll_pkg::node_t par_rd_q, jta_q, jtb_q;
	bll_pkg::depth_t dep_a_q, dep_b_q;

	logic par_we;
	logic [AW-1:0] par_waddr;
	bll_pkg::node_t par_wdata;
	logic dep_we;
	logic jt_we;
	logic [JW-1:0] jt_waddr, jta_addr, jtb_addr;
	bll_pkg::node_t jt_wdata;

	logic accept, load_ok, a_ok, b_ok, cnt_ok, p_ok, k_last;
	bll_pkg::depth_t diff;

	assign accept = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign lvl_m1 = lvl_q - LW'(1);
	assign k_last = (lvl_q == LVL_LAST);

	assign load_ok = (req.node_a != '0) && (32'(req.node_a) < NODES);
	assign a_ok = load_ok && (req.node_a <= node_count_q);
	assign b_ok = (req.node_b != '0) && (req.node_b <= node_count_q) &&
		(32'(req.node_b) < NODES);
	assign cnt_ok = (cnt_q != '0) && (CW'(cnt_q) <= CW'(node_count_q));
	assign p_ok = (par_rd_q != '0) && (par_rd_q <= node_count_q) && (32'(par_rd_q) < NODES);
	assign diff = (dep_a_q < dep_b_q) ? (dep_b_q - dep_a_q) : (dep_a_q - dep_b_q);

	// Memory port steering
	always_comb begin
		par_we = 1'b0;
		par_waddr = cnt_q;
		par_wdata = '0;
		dep_we = 1'b0;
		if (state_q == ST_CLR) begin
			par_we = 1'b1;
		end else if (accept && req.func == bll_pkg::FN_LOAD && load_ok) begin
			par_we = 1'b1;
			dep_we = 1'b1;
			par_waddr = AW'(req.node_a);
			par_wdata = req.parent_none ? '0 : req.node_b;
		end
	end

	always_comb begin
		jt_we = 1'b0;
		jt_waddr = {cnt_q, lvl_q};
		jt_wdata = '0;
		jta_addr = {AW'(u_q), lvl_q};
		jtb_addr = {AW'(w_q), lvl_q};
		case (state_q)
			ST_B0_WR: begin
				jt_we = 1'b1;
				jt_waddr = {cnt_q, LW'(0)};
				jt_wdata = (cnt_ok && p_ok) ? par_rd_q : '0;
			end
			ST_BH_RD1: jta_addr = {cnt_q, lvl_m1};
			ST_BH_RD2: jta_addr = {AW'(jta_q), lvl_m1};
			ST_BH_WR: begin
				jt_we = 1'b1;
				jt_wdata = midz_q ? '0 : jta_q;
			end
			ST_K_STEP: jta_addr = {AW'(c_q), lvl_q};
			ST_L_FRD: jta_addr = {AW'(u_q), LW'(0)};
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (par_we)
			par_mem[par_waddr] <= par_wdata;
		par_rd_q <= par_mem[cnt_q];
	end

	always_ff @(posedge clk) begin
		if (dep_we)
			dep_mem[AW'(req.node_a)] <= req.node_depth;
		dep_a_q <= dep_mem[AW'(u_q)];
		dep_b_q <= dep_mem[AW'(w_q)];
	end

	always_ff @(posedge clk) begin
		if (jt_we)
			jt_mem[jt_waddr] <= jt_wdata;
		jta_q <= jt_mem[jta_addr];
		jtb_q <= jt_mem[jtb_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= bll_pkg::NODE_COUNT_RST;
		end else if (cfg_we) begin
			node_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			cnt_q <= '0;
			lvl_q <= '0;
			u_q <= '0;
			w_q <= '0;
			c_q <= '0;
			k_q <= '0;
			res_q <= '0;
			lca_q <= 1'b0;
			sel_q <= 1'b0;
			midz_q <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_node_q <= '0;
			rsp_found_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready && state_q != ST_DONE)
				rsp_valid_q <= 1'b0;
			case (state_q)
				ST_CLR: begin
					if (cnt_q == CNT_LAST) begin
						cnt_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						u_q <= req.node_a;
						w_q <= req.node_b;
						c_q <= req.node_a;
						k_q <= req.jump_count;
						lca_q <= (req.func == bll_pkg::FN_LCA);
						lvl_q <= '0;
						cnt_q <= '0;
						res_q <= '0;
						case (req.func)
							bll_pkg::FN_BUILD: state_q <= ST_B0_RD;
							bll_pkg::FN_KTH: begin
								if (a_ok && (req.jump_count >> LEVELS) == '0)
									state_q <= ST_K_STEP;
								else
									state_q <= ST_DONE;
							end
							bll_pkg::FN_LCA: begin
								if (a_ok && b_ok)
									state_q <= ST_L_DEP;
								else
									state_q <= ST_DONE;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_B0_RD: state_q <= ST_B0_WR;
				ST_B0_WR: begin
					if (cnt_q == CNT_LAST) begin
						cnt_q <= '0;
						lvl_q <= LW'(1);
						state_q <= ST_BH_RD1;
					end else begin
						cnt_q <= cnt_q + AW'(1);
						state_q <= ST_B0_RD;
					end
				end
				ST_BH_RD1: state_q <= ST_BH_RD2;
				ST_BH_RD2: begin
					midz_q <= (jta_q == '0);
					state_q <= ST_BH_WR;
				end
				ST_BH_WR: begin
					if (cnt_q != CNT_LAST) begin
						cnt_q <= cnt_q + AW'(1);
						state_q <= ST_BH_RD1;
					end else if (k_last) begin
						cnt_q <= '0;
						res_q <= '0;
						state_q <= ST_DONE;
					end else begin
						cnt_q <= '0;
						lvl_q <= lvl_q + LW'(1);
						state_q <= ST_BH_RD1;
					end
				end
				ST_K_STEP: begin
					if (k_q[0] && c_q != '0) begin
						state_q <= ST_K_WAIT;
					end else if (k_last) begin
						state_q <= ST_K_END;
					end else begin
						lvl_q <= lvl_q + LW'(1);
						k_q <= k_q >> 1;
					end
				end
				ST_K_WAIT: begin
					c_q <= jta_q;
					if (k_last) begin
						state_q <= ST_K_END;
					end else begin
						lvl_q <= lvl_q + LW'(1);
						k_q <= k_q >> 1;
						state_q <= ST_K_STEP;
					end
				end
				ST_K_END: begin
					if (!lca_q) begin
						res_q <= c_q;
						state_q <= ST_DONE;
					end else begin
						if (sel_q)
							w_q <= c_q;
						else
							u_q <= c_q;
						state_q <= ST_L_CHK;
					end
				end
				ST_L_DEP: state_q <= ST_L_DIFF;
				ST_L_DIFF: begin
					lvl_q <= '0;
					k_q <= diff;
					sel_q <= (dep_a_q < dep_b_q);
					c_q <= (dep_a_q < dep_b_q) ? w_q : u_q;
					if (dep_a_q == dep_b_q) begin
						state_q <= ST_L_CHK;
					end else if ((diff >> LEVELS) != '0) begin
						res_q <= '0;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_K_STEP;
					end
				end
				ST_L_CHK: begin
					if (u_q == '0 || w_q == '0) begin
						res_q <= '0;
						state_q <= ST_DONE;
					end else if (u_q == w_q) begin
						res_q <= u_q;
						state_q <= ST_DONE;
					end else begin
						lvl_q <= LVL_LAST;
						state_q <= ST_L_LRD;
					end
				end
				ST_L_LRD: state_q <= ST_L_LCMP;
				ST_L_LCMP: begin
					// lift both only while their ancestors still differ
					if (jta_q != jtb_q) begin
						u_q <= jta_q;
						w_q <= jtb_q;
					end
					if (lvl_q == '0) begin
						state_q <= ST_L_FRD;
					end else begin
						lvl_q <= lvl_m1;
						state_q <= ST_L_LRD;
					end
				end
				ST_L_FRD: state_q <= ST_L_FWAIT;
				ST_L_FWAIT: begin
					res_q <= jta_q;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// hold the result until the output register is free
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						rsp_node_q <= res_q;
						rsp_found_q <= (res_q != '0);
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.result_node = rsp_node_q;
	assign rsp.found = rsp_found_q;

	`BLL_ASSERT(a_busy_after_accept, accept |=> !req.ready, "ready high right after a request")
	`BLL_ASSERT(a_found_match, rsp.valid |-> (rsp.found == (rsp.result_node != '0)), "found disagrees with result node")
	`BLL_ASSERT(a_rsp_from_done, $rose(rsp.valid) |-> ($past(state_q) == ST_DONE), "response raised outside done")
	`BLL_NEVER(a_lvl_range, (lvl_q > LVL_LAST), "level index beyond table")
endmodule
